@@ src/fra_pkg.sv @@
`timescale 1ns / 1ps

package fra_pkg;

	// request codes
	localparam logic [2:0] REQ_GET     = 3'd0;
	localparam logic [2:0] REQ_COMMIT  = 3'd1;
	localparam logic [2:0] REQ_PEEK    = 3'd2;
	localparam logic [2:0] REQ_RELEASE = 3'd3;
	localparam logic [2:0] REQ_CLEAR   = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// register byte-address bit that selects past the ring_bytes register
	localparam int REG_SEL_BIT = 2;

endpackage

@@ src/fra_ram.sv @@
`timescale 1ns / 1ps

module fra_ram #(
	parameter int WIDTH = 82,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/frame_ring_allocator_core.sv @@
// Frame ring allocator: offset bookkeeping for an external byte ring that
// holds variable-size frames, each kept contiguous.
// Request channel: drive req_type, frame_len, frame_key and no_draw with
// start high; the item is taken at the edge where start is high and busy
// is low. Requests: get region, commit, peek oldest, release oldest, clear.
// Result channel: one result per item, shown for exactly one cycle with
// done high. The receiver cannot stall; sample the result when done is high.
// Sequence: the accepting edge reads the queue head from the descriptor RAM;
// the next cycle computes the update and its closing edge loads counters and
// result, so done is high in the cycle after that compute cycle. busy is
// high only in the compute cycle, so a new item is taken at best at the
// edge that ends its predecessor's result cycle.
// Configuration: APB port, ring_bytes at byte address 0. A write empties
// the ring; write only while the block is idle. Sizes keep their low
// OFFSET_BITS+1 bits; values above 2^OFFSET_BITS are then clamped to it.
// Reset: empties the ring, ring_bytes goes to 2^OFFSET_BITS. The
// descriptor RAM is not cleared; only written entries are ever used.
// Error requests (no space, empty, queue full) report a status and leave
// the state untouched.
`timescale 1ns / 1ps

module frame_ring_allocator_core #(
	parameter int DESC_DEPTH  = 16,
	parameter int OFFSET_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// request channel
	input  logic                   start,
	output logic                   busy,
	input  logic [2:0]             req_type,
	input  logic [OFFSET_BITS:0]   frame_len,
	input  logic signed [31:0]     frame_key,
	input  logic                   no_draw,
	// result channel
	output logic                   done,
	output logic [1:0]             status,
	output logic [OFFSET_BITS-1:0] region_offset,
	output logic [OFFSET_BITS:0]   out_len,
	output logic signed [31:0]     out_key,
	output logic                   out_no_draw,
	output logic [OFFSET_BITS:0]   free_bytes,
	output logic [OFFSET_BITS:0]   ready_bytes,
	// configuration port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam int OB    = OFFSET_BITS;
	localparam int LW    = OFFSET_BITS + 1;
	localparam int IDX_W = $clog2(DESC_DEPTH);
	localparam int CNT_W = $clog2(DESC_DEPTH + 1);
	localparam int ENT_W = OB + LW + 33;
	localparam logic [LW-1:0]    RING_MAX = LW'(1) << OB;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DESC_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DESC_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;

	// configuration and ring state
	logic [LW-1:0]    ring_q;
	logic [OB-1:0]    wr_off_q, rd_off_q;
	logic [LW-1:0]    free_q, ready_q;
	logic [IDX_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] used_q;

	// captured request
	logic [2:0]    req_q;
	logic [LW-1:0] len_q;
	logic [31:0]   key_q;
	logic          flag_q;

	// registered result
	logic          done_q;
	logic [1:0]    status_q;
	logic [OB-1:0] roff_q;
	logic [LW-1:0] olen_q;
	logic [31:0]   okey_q;
	logic          oflag_q;

	// next-state values
	logic [OB-1:0]    wr_off_d, rd_off_d;
	logic [LW-1:0]    free_d, ready_d;
	logic [IDX_W-1:0] head_d, tail_d;
	logic [CNT_W-1:0] used_d;
	logic [1:0]       status_d;
	logic [OB-1:0]    roff_d;
	logic [LW-1:0]    olen_d;
	logic [31:0]      okey_d;
	logic             oflag_d;
	logic             ram_we;

	logic accept, exec, cfg_wr;
	logic [32:0]      wdata_ext;
	logic [LW-1:0]    ring_wr;

	// descriptor RAM entry: {offset, length, key, flag}
	logic [ENT_W-1:0] ram_rdata, ram_wdata;
	logic [OB-1:0]    ent_off;
	logic [LW-1:0]    ent_len;
	logic [31:0]      ent_key;
	logic             ent_flag;

	// release arithmetic
	logic [LW:0]   skip, rd_sum, rd_wrap;
	logic [LW+1:0] free_sum;
	logic [LW:0]   wr_sum;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign exec   = (state_q == S_EXEC);
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && !paddr[fra_pkg::REG_SEL_BIT];
	assign prdata = paddr[fra_pkg::REG_SEL_BIT] ? 32'd0 : 32'({1'b0, ring_q});

	// cut the written size to OFFSET_BITS+1 bits, then clamp it to 2^OFFSET_BITS
	assign wdata_ext = {1'b0, pwdata};
	assign ring_wr   = (wdata_ext[LW-1:0] > RING_MAX) ? RING_MAX : wdata_ext[LW-1:0];

	assign {ent_off, ent_len, ent_key, ent_flag} = ram_rdata;
	assign ram_wdata = {wr_off_q, len_q, key_q, flag_q};

	// head entry is read on every accept, ready for the execute cycle
	fra_ram #(
		.WIDTH(ENT_W),
		.DEPTH(DESC_DEPTH)
	) u_desc_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tail_q),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	// release: gap skipped before the oldest frame, new read offset, freed bytes
	always_comb begin
		if (ent_off >= rd_off_q) begin
			skip = (LW+1)'(ent_off) - (LW+1)'(rd_off_q);
		end else begin
			skip = (LW+1)'(ent_off) + (LW+1)'(ring_q) - (LW+1)'(rd_off_q);
		end
		rd_sum   = (LW+1)'(ent_off) + (LW+1)'(ent_len);
		rd_wrap  = (rd_sum >= (LW+1)'(ring_q)) ? rd_sum - (LW+1)'(ring_q) : rd_sum;
		free_sum = (LW+2)'(free_q) + (LW+2)'(ent_len) + (LW+2)'(skip);
		wr_sum   = (LW+1)'(wr_off_q) + (LW+1)'(len_q);
	end

	always_comb begin
		wr_off_d = wr_off_q;
		rd_off_d = rd_off_q;
		free_d   = free_q;
		ready_d  = ready_q;
		head_d   = head_q;
		tail_d   = tail_q;
		used_d   = used_q;
		status_d = fra_pkg::ST_OK;
		roff_d   = '0;
		olen_d   = '0;
		okey_d   = '0;
		oflag_d  = 1'b0;
		ram_we   = 1'b0;
		unique case (req_q)
			fra_pkg::REQ_GET: begin
				if (len_q > free_q) begin
					status_d = fra_pkg::ST_NO_SPACE;
				end else if (rd_off_q >= wr_off_q) begin
					// read offset at or past write offset: rewind both offsets only if the queue is drained
					if (used_q == '0) begin
						wr_off_d = '0;
						rd_off_d = '0;
						roff_d   = '0;
					end else begin
						roff_d = wr_off_q;
					end
				end else if (ring_q - LW'(wr_off_q) >= len_q) begin
					roff_d = wr_off_q;
				end else if (LW'(rd_off_q) >= len_q) begin
					// wrap to offset 0, count the skipped tail as used
					free_d   = free_q - (ring_q - LW'(wr_off_q));
					wr_off_d = '0;
					roff_d   = '0;
				end else begin
					status_d = fra_pkg::ST_NO_SPACE;
				end
			end
			fra_pkg::REQ_COMMIT: begin
				if (used_q >= FULL_CNT) begin
					status_d = fra_pkg::ST_FULL;
				end else if (len_q > free_q) begin
					status_d = fra_pkg::ST_NO_SPACE;
				end else begin
					ram_we   = 1'b1;
					tail_d   = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
					used_d   = used_q + 1'b1;
					roff_d   = wr_off_q;
					ready_d  = ready_q + len_q;
					free_d   = free_q - len_q;
					wr_off_d = (wr_sum >= (LW+1)'(ring_q)) ?
						OB'(wr_sum - (LW+1)'(ring_q)) : OB'(wr_sum);
				end
			end
			fra_pkg::REQ_PEEK: begin
				if (used_q == '0) begin
					status_d = fra_pkg::ST_EMPTY;
				end else begin
					roff_d  = ent_off;
					olen_d  = ent_len;
					okey_d  = ent_key;
					oflag_d = ent_flag;
				end
			end
			fra_pkg::REQ_RELEASE: begin
				if (used_q == '0) begin
					status_d = fra_pkg::ST_EMPTY;
				end else begin
					head_d   = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
					used_d   = used_q - 1'b1;
					free_d   = (free_sum > (LW+2)'(ring_q)) ? ring_q : LW'(free_sum);
					ready_d  = (ready_q > ent_len) ? ready_q - ent_len : '0;
					rd_off_d = (rd_wrap >= (LW+1)'(ring_q)) ? '0 : OB'(rd_wrap);
				end
			end
			fra_pkg::REQ_CLEAR: begin
				wr_off_d = '0;
				rd_off_d = '0;
				free_d   = ring_q;
				ready_d  = '0;
				head_d   = '0;
				tail_d   = '0;
				used_d   = '0;
			end
			default: begin
				// unknown request: report ok, change nothing
			end
		endcase
	end

	// control and ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ring_q   <= RING_MAX;
			wr_off_q <= '0;
			rd_off_q <= '0;
			free_q   <= RING_MAX;
			ready_q  <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			used_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= exec;
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_EXEC;
				S_EXEC: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (cfg_wr) begin
				// new size: empty the ring
				ring_q   <= ring_wr;
				wr_off_q <= '0;
				rd_off_q <= '0;
				free_q   <= ring_wr;
				ready_q  <= '0;
				head_q   <= '0;
				tail_q   <= '0;
				used_q   <= '0;
			end else if (exec) begin
				wr_off_q <= wr_off_d;
				rd_off_q <= rd_off_d;
				free_q   <= free_d;
				ready_q  <= ready_d;
				head_q   <= head_d;
				tail_q   <= tail_d;
				used_q   <= used_d;
			end
		end
	end

	// request capture and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_type;
			len_q  <= frame_len;
			key_q  <= frame_key;
			flag_q <= no_draw;
		end
		if (exec) begin
			status_q <= status_d;
			roff_q   <= roff_d;
			olen_q   <= olen_d;
			okey_q   <= okey_d;
			oflag_q  <= oflag_d;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign region_offset = roff_q;
	assign out_len       = olen_q;
	assign out_key       = okey_q;
	assign out_no_draw   = oflag_q;
	assign free_bytes    = free_q;
	assign ready_bytes   = ready_q;

endmodule

@@ src/fra_checker.sv @@
`timescale 1ns / 1ps

module fra_checker #(
	parameter int OFF_W = 24
) (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic [1:0]       status,
	input logic [OFF_W-1:0] region_offset,
	input logic [OFF_W:0]   out_len,
	input logic [OFF_W:0]   ready_bytes
);

	// every accepted item raises done once its compute cycle has ended
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted item gave no result after two cycles");

	// accepting an item raises busy, holding off the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	// no result without an item in flight
	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an item in execution");

	// an empty queue reports no frame and no ready bytes
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == fra_pkg::ST_EMPTY) |->
			(region_offset == '0 && out_len == '0 && ready_bytes == '0))
		else $error("empty status with frame data or ready bytes");

endmodule

bind frame_ring_allocator_core fra_checker #(
	.OFF_W(OFFSET_BITS)
) u_fra_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.region_offset(region_offset),
	.out_len      (out_len),
	.ready_bytes  (ready_bytes)
);

@@ bench/frame_ring_allocator_core_test.sv @@
`timescale 1ns / 1ps

module frame_ring_allocator_core_test;

	localparam int OFF_BITS = 24;
	localparam int DESC_SLOTS = 16;
	localparam longint unsigned RING_MAX = 64'd1 << OFF_BITS;
	localparam logic [31:0] LEN_MASK = 32'h01FF_FFFF;
	localparam int MAX_PRINTED = 50;

	typedef struct packed {
		logic [2:0]  req;
		logic [24:0] len;
		logic [31:0] key;
		logic        flag;
	} req_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [23:0] offset;
		logic [24:0] len;
		logic [31:0] key;
		logic        flag;
		logic [24:0] free;
		logic [24:0] ready;
	} alloc_result_t;

	// clock, reset and block ports; every input starts at a known value
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [2:0]         req_type = '0;
	logic [24:0]        frame_len = '0;
	logic signed [31:0] frame_key = '0;
	logic               no_draw = 1'b0;
	logic               done;
	logic [1:0]         status;
	logic [23:0]        region_offset;
	logic [24:0]        out_len;
	logic signed [31:0] out_key;
	logic               out_no_draw;
	logic [24:0]        free_bytes;
	logic [24:0]        ready_bytes;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	frame_ring_allocator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.frame_len(frame_len),
		.frame_key(frame_key),
		.no_draw(no_draw),
		.done(done),
		.status(status),
		.region_offset(region_offset),
		.out_len(out_len),
		.out_key(out_key),
		.out_no_draw(out_no_draw),
		.free_bytes(free_bytes),
		.ready_bytes(ready_bytes),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// items waiting to be driven, and results owed by the block
	req_item_t     pending_reqs[$];
	alloc_result_t expected_results[$];

	int        mismatches = 0;
	bit        item_taken = 1'b0;
	bit        no_idle = 1'b0;
	int        gap_left = 0;
	req_item_t cur_item;

	// shadow copy of the allocator bookkeeping
	longint unsigned ring_size;
	longint unsigned wr_off;
	longint unsigned rd_off;
	longint unsigned free_cnt;
	longint unsigned ready_cnt;
	longint unsigned slot_off[DESC_SLOTS];
	longint unsigned slot_len[DESC_SLOTS];
	logic [31:0]     slot_key[DESC_SLOTS];
	logic            slot_flag[DESC_SLOTS];
	int              slot_head;
	int              slot_tail;
	int              slot_used;

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINTED)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	function automatic longint unsigned clamp_ring(input logic [31:0] value);
		longint unsigned v;
		v = 64'(value & LEN_MASK);
		return (v > RING_MAX) ? RING_MAX : v;
	endfunction

	task automatic empty_ring_model();
		wr_off = 0;
		rd_off = 0;
		free_cnt = ring_size;
		ready_cnt = 0;
		slot_head = 0;
		slot_tail = 0;
		slot_used = 0;
	endtask

	// Work out the one result an accepted item causes, and advance the shadow state.
	task automatic alloc_predict(input req_item_t it, output alloc_result_t res);
		longint unsigned len;
		longint unsigned d;
		longint unsigned sz;
		longint unsigned skip;
		res = '0;
		len = 64'(it.len);
		case (it.req)
			fra_pkg::REQ_GET: begin
				if (len > free_cnt) begin
					res.status = fra_pkg::ST_NO_SPACE;
				end else if (rd_off >= wr_off) begin
					// rewind to the start only when no frame is queued
					if (slot_used == 0) begin
						wr_off = 0;
						rd_off = 0;
					end
					res.offset = wr_off[23:0];
				end else if (ring_size - wr_off >= len) begin
					res.offset = wr_off[23:0];
				end else if (rd_off >= len) begin
					// wrap to 0 and count the skipped tail as used
					free_cnt -= ring_size - wr_off;
					wr_off = 0;
					res.offset = '0;
				end else begin
					res.status = fra_pkg::ST_NO_SPACE;
				end
			end
			fra_pkg::REQ_COMMIT: begin
				if (slot_used >= DESC_SLOTS) begin
					res.status = fra_pkg::ST_FULL;
				end else if (len > free_cnt) begin
					res.status = fra_pkg::ST_NO_SPACE;
				end else begin
					slot_off[slot_tail] = wr_off;
					slot_len[slot_tail] = len;
					slot_key[slot_tail] = it.key;
					slot_flag[slot_tail] = it.flag;
					slot_tail = (slot_tail + 1 >= DESC_SLOTS) ? 0 : slot_tail + 1;
					slot_used++;
					res.offset = wr_off[23:0];
					ready_cnt += len;
					free_cnt -= len;
					wr_off += len;
					if (wr_off >= ring_size)
						wr_off -= ring_size;
				end
			end
			fra_pkg::REQ_PEEK: begin
				if (slot_used == 0) begin
					res.status = fra_pkg::ST_EMPTY;
				end else begin
					res.offset = slot_off[slot_head][23:0];
					res.len = slot_len[slot_head][24:0];
					res.key = slot_key[slot_head];
					res.flag = slot_flag[slot_head];
				end
			end
			fra_pkg::REQ_RELEASE: begin
				if (slot_used == 0) begin
					res.status = fra_pkg::ST_EMPTY;
				end else begin
					d = slot_off[slot_head];
					sz = slot_len[slot_head];
					// free any gap skipped ahead of the oldest frame too
					skip = (d >= rd_off) ? d - rd_off : d + ring_size - rd_off;
					slot_head = (slot_head + 1 >= DESC_SLOTS) ? 0 : slot_head + 1;
					slot_used--;
					free_cnt += sz + skip;
					if (free_cnt > ring_size)
						free_cnt = ring_size;
					ready_cnt = (ready_cnt > sz) ? ready_cnt - sz : 0;
					rd_off = d + sz;
					if (rd_off >= ring_size)
						rd_off -= ring_size;
					if (rd_off >= ring_size)
						rd_off = 0;
				end
			end
			fra_pkg::REQ_CLEAR: begin
				empty_ring_model();
			end
			default: begin
			end
		endcase
		res.free = free_cnt[24:0];
		res.ready = ready_cnt[24:0];
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Mostly lengths well inside the ring, with zero, the whole ring and raw noise mixed in.
	function automatic logic [24:0] pick_len(input longint unsigned ring);
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 10)
			return ring[24:0];
		if (r < 13)
			return 25'($urandom() & LEN_MASK);
		if (r < 70)
			return 25'($urandom_range(0, int'(ring / 8)));
		return 25'($urandom_range(0, int'(ring / 2)));
	endfunction

	function automatic void queue_req(input logic [2:0] rq, input logic [24:0] len,
			input logic [31:0] key, input logic flag);
		req_item_t it;
		it.req = rq;
		it.len = len;
		it.key = key;
		it.flag = flag;
		pending_reqs.insert(pending_reqs.size(), it);
	endfunction

	// Fill one phase: mostly get-then-commit pairs, releases and peeks, the rest noise.
	task automatic load_random(input longint unsigned ring, input int count);
		int made;
		int r;
		logic [24:0] len;
		made = 0;
		while (made < count) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				len = pick_len(ring);
				queue_req(fra_pkg::REQ_GET, len, $urandom(), 1'($urandom_range(0, 1)));
				queue_req(fra_pkg::REQ_COMMIT, len, $urandom(), 1'($urandom_range(0, 1)));
				made += 2;
			end else begin
				if (r < 65)
					queue_req(fra_pkg::REQ_RELEASE, 25'($urandom() & LEN_MASK),
						$urandom(), 1'($urandom_range(0, 1)));
				else if (r < 78)
					queue_req(fra_pkg::REQ_PEEK, 25'($urandom() & LEN_MASK),
						$urandom(), 1'($urandom_range(0, 1)));
				else
					queue_req(3'($urandom_range(0, 7)), 25'($urandom() & LEN_MASK),
						$urandom(), 1'($urandom_range(0, 1)));
				made++;
			end
		end
	endtask

	// Hold until every item has been taken and every result has shown.
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// APB write of ring_bytes: setup cycle, then access cycle.
	task automatic write_ring_size(input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= '0;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Driver: present the next item at the falling edge, hold it until taken,
	// then idle for the chosen gap.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || item_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				cur_item = pending_reqs[0];
				pending_reqs.delete(0);
				req_type <= cur_item.req;
				frame_len <= cur_item.len;
				frame_key <= cur_item.key;
				no_draw <= cur_item.flag;
				start <= 1'b1;
				gap_left = pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: at each rising edge track config writes, check a shown result
	// against the oldest expectation, and predict for an item taken here.
	always @(posedge clk) begin
		alloc_result_t exp_r;
		alloc_result_t new_r;
		req_item_t     seen;
		if (!arst_n) begin
			item_taken = 1'b0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == '0) begin
				ring_size = clamp_ring(pwdata);
				empty_ring_model();
			end
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result shown with nothing expected");
				end else begin
					exp_r = expected_results[0];
					expected_results.delete(0);
					check_field("status", 32'(status), 32'(exp_r.status));
					check_field("region_offset", 32'(region_offset), 32'(exp_r.offset));
					check_field("out_len", 32'(out_len), 32'(exp_r.len));
					check_field("out_key", out_key, exp_r.key);
					check_field("out_no_draw", 32'(out_no_draw), 32'(exp_r.flag));
					check_field("free_bytes", 32'(free_bytes), 32'(exp_r.free));
					check_field("ready_bytes", 32'(ready_bytes), 32'(exp_r.ready));
				end
			end
			item_taken = start && !busy;
			if (item_taken) begin
				seen.req = req_type;
				seen.len = frame_len;
				seen.key = frame_key;
				seen.flag = no_draw;
				alloc_predict(seen, new_r);
				expected_results.insert(expected_results.size(), new_r);
			end
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#5ms;
		$display("** frame_ring_allocator_core: FAILED **");
		$finish;
	end

	initial begin
		logic [31:0] ring_plan[10];
		ring_plan = '{32'd0, 32'd1, 32'd10, 32'd37, 32'd256, 32'd1000, 32'd65536,
			32'h0100_0000, 32'h01FF_FFFF, 32'd0};
		ring_plan[9] = $urandom_range(1, 32'h0100_0000);

		ring_size = RING_MAX;
		empty_ring_model();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, full-size ring after reset: empty queue, size extremes,
		// key extremes, unknown request types and clear
		queue_req(fra_pkg::REQ_PEEK, '0, '0, 1'b0);
		queue_req(fra_pkg::REQ_RELEASE, '0, '0, 1'b0);
		queue_req(fra_pkg::REQ_GET, '0, '0, 1'b0);
		queue_req(fra_pkg::REQ_GET, 25'h100_0000, '0, 1'b0);
		queue_req(fra_pkg::REQ_GET, 25'h1FF_FFFF, 32'hFFFF_FFFF, 1'b1);
		queue_req(fra_pkg::REQ_COMMIT, 25'd1000, 32'h7FFF_FFFF, 1'b1);
		queue_req(fra_pkg::REQ_COMMIT, '0, 32'h8000_0000, 1'b0);
		queue_req(fra_pkg::REQ_PEEK, '0, '0, 1'b0);
		queue_req(fra_pkg::REQ_RELEASE, '0, '0, 1'b0);
		queue_req(fra_pkg::REQ_PEEK, '0, '0, 1'b0);
		queue_req(fra_pkg::REQ_RELEASE, '0, '0, 1'b0);
		queue_req(fra_pkg::REQ_RELEASE, '0, '0, 1'b0);
		queue_req(fra_pkg::REQ_COMMIT, 25'h1FF_FFFF, 32'h1234_5678, 1'b1);
		queue_req(3'd5, 25'h1FF_FFFF, 32'hFFFF_FFFF, 1'b1);
		queue_req(3'd6, '0, '0, 1'b0);
		queue_req(3'd7, 25'd77, 32'h55AA_55AA, 1'b1);
		queue_req(fra_pkg::REQ_CLEAR, '0, '0, 1'b0);
		wait_drained();

		// directed wrap on a tiny ring: the get skips the tail, and the
		// third release frees that skipped gap along with its frame
		write_ring_size(32'd10);
		queue_req(fra_pkg::REQ_COMMIT, 25'd4, 32'h0000_0001, 1'b0);
		queue_req(fra_pkg::REQ_COMMIT, 25'd4, 32'h0000_0002, 1'b1);
		queue_req(fra_pkg::REQ_RELEASE, '0, '0, 1'b0);
		queue_req(fra_pkg::REQ_GET, 25'd3, '0, 1'b0);
		queue_req(fra_pkg::REQ_COMMIT, 25'd3, 32'hDEAD_BEEF, 1'b1);
		queue_req(fra_pkg::REQ_RELEASE, '0, '0, 1'b0);
		queue_req(fra_pkg::REQ_RELEASE, '0, '0, 1'b0);
		queue_req(fra_pkg::REQ_PEEK, '0, '0, 1'b0);
		load_random(clamp_ring(32'd10), 36);
		wait_drained();

		// random phases over many ring sizes, zero and the clamped one among them
		foreach (ring_plan[i]) begin
			write_ring_size(ring_plan[i]);
			no_idle = ($urandom_range(0, 3) == 0);
			load_random(clamp_ring(ring_plan[i]), 36);
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results still expected at end of run");
		if (mismatches == 0)
			$display("** frame_ring_allocator_core: PASSED **");
		else
			$display("** frame_ring_allocator_core: FAILED **");
		$finish;
	end

endmodule
